// ===== hw/rtl/grb_pkg.sv =====
package grb_pkg;

  // Glyph geometry
  localparam int MAX_GLYPH_WIDTH = 16;
  localparam int ROW_W           = 16;
  localparam int COL_W           = $clog2(ROW_W);
  localparam int GLYPH_W_LIMIT   = (MAX_GLYPH_WIDTH < ROW_W) ? MAX_GLYPH_WIDTH : ROW_W;

  // Field widths
  localparam int PEN_W    = 12;
  localparam int TOP_W    = 6;
  localparam int SIZE_W   = 5;
  localparam int ROWNUM_W = 4;
  localparam int COLOUR_W = 8;
  localparam int REG_W    = 13;
  localparam int ADDR_W   = 24;

  // Stream widths
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 32;

  // Register reset values
  localparam logic [REG_W-1:0] FRAME_WIDTH_RESET  = 13'd1024;
  localparam logic [REG_W-1:0] FRAME_HEIGHT_RESET = 13'd768;

  // Register indexes
  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // One input item
  typedef struct packed {
    logic [COLOUR_W-1:0] colour;
    logic [ROWNUM_W-1:0] row_number;
    logic [SIZE_W-1:0]   glyph_height;
    logic [SIZE_W-1:0]   glyph_width;
    logic [TOP_W-1:0]    glyph_top;
    logic [PEN_W-1:0]    pen_y;
    logic [PEN_W-1:0]    pen_x;
    logic [ROW_W-1:0]    row_bits;
    logic                bold;
  } in_item_t;

endpackage

// ===== hw/rtl/glyph_row_blitter.sv =====
// Glyph row blitter: each input transfer carries one 16-bit glyph row; the block clips it
// against the framebuffer size in frame_width/frame_height and emits one pixel write per
// visible set bit, left column first, with tlast on the final write of the row. Rows that
// draw nothing produce no output transfer. The first write leaves once the row has passed the
// input, clip and emit registers; after that the single pixel output register sends one
// write per cycle while m_tready accepts it, so a row makes at most 16 writes, and the next
// row is taken while the current one is still being sent. Write the configuration registers
// only while the block is idle.
module glyph_row_blitter
  import grb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Input rows
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // tdata: row_bits[15:0], pen_x[27:16], pen_y[39:28], glyph_top[45:40],
  //        glyph_width[50:46], glyph_height[55:51], row_number[59:56], colour[67:60]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tuser,   // bold
  // Pixel writes
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // pixel_address[23:0], pixel_colour[31:24]
  output logic                  m_tuser,   // pair
  output logic                  m_tlast,   // last
  // Configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [REG_W-1:0]      cfg_data
);

  logic [REG_W-1:0] frame_width;
  logic [REG_W-1:0] frame_height;

  // Input stage
  in_item_t a_item;
  logic     a_valid;
  logic     a_take;

  // Clip stage
  logic                b_valid;
  logic                b_take;
  logic [ROW_W-1:0]    b_mask;
  logic [ADDR_W-1:0]   b_prod;
  logic [PEN_W-1:0]    b_px;
  logic [COLOUR_W-1:0] b_colour;
  logic                b_bold;

  // Emit stage
  logic [ROW_W-1:0]    c_mask;
  logic [ADDR_W-1:0]   c_base;
  logic [COLOUR_W-1:0] c_colour;
  logic                c_bold;
  logic [ROW_W-1:0]    c_low;
  logic [ROW_W-1:0]    c_mask_next;
  logic [COL_W-1:0]    c_col;
  logic                c_take;
  logic                emit;

  // Clip logic signals
  logic [SIZE_W-1:0]   w_sat;
  logic [REG_W:0]      x_sum;
  logic [REG_W-1:0]    px_ext;
  logic [SIZE_W-1:0]   w_clip;
  logic [REG_W-1:0]    ty;
  logic [REG_W:0]      y_sum;
  logic [REG_W-1:0]    h_clip;
  logic                draw;
  logic [ROW_W:0]      w_ones;
  logic [REG_W-1:0]    y_row;
  logic [2*REG_W-1:0]  prod;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake chain: each stage advances when the next one frees up
  assign emit        = (c_mask != '0) && (!m_tvalid || m_tready);
  assign c_low       = c_mask & (~c_mask + ROW_W'(1));
  assign c_mask_next = emit ? (c_mask & ~c_low) : c_mask;
  assign c_take      = (c_mask_next == '0);
  assign b_take      = !b_valid || c_take;
  assign a_take      = !a_valid || b_take;
  assign s_tready    = a_take;

  // Register the input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_take) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_take && s_tvalid) begin
      a_item.row_bits     <= s_tdata[15:0];
      a_item.pen_x        <= s_tdata[27:16];
      a_item.pen_y        <= s_tdata[39:28];
      a_item.glyph_top    <= s_tdata[45:40];
      a_item.glyph_width  <= s_tdata[50:46];
      a_item.glyph_height <= s_tdata[55:51];
      a_item.row_number   <= s_tdata[59:56];
      a_item.colour       <= s_tdata[67:60];
      a_item.bold         <= s_tuser;
    end
  end

  // Clip width and height, build the column mask and the row address
  always_comb begin
    w_sat  = (a_item.glyph_width > SIZE_W'(GLYPH_W_LIMIT)) ? SIZE_W'(GLYPH_W_LIMIT)
                                                          : a_item.glyph_width;
    px_ext = {1'b0, a_item.pen_x};
    x_sum  = {1'b0, px_ext} + (REG_W+1)'(w_sat) + (REG_W+1)'(a_item.bold);
    if (x_sum > {1'b0, frame_width}) begin
      w_clip = (px_ext < frame_width)
             ? SIZE_W'(frame_width - px_ext - REG_W'(a_item.bold)) : '0;
    end else begin
      w_clip = w_sat;
    end

    ty    = {1'b0, a_item.pen_y} + REG_W'(a_item.glyph_top);
    y_sum = {1'b0, ty} + (REG_W+1)'(a_item.glyph_height);
    if (y_sum > {1'b0, frame_height}) begin
      h_clip = (ty < frame_height) ? (frame_height - ty) : '0;
    end else begin
      h_clip = REG_W'(a_item.glyph_height);
    end
    draw = REG_W'(a_item.row_number) < h_clip;

    w_ones = ((ROW_W+1)'(1) << w_clip) - (ROW_W+1)'(1);
    y_row  = ty + REG_W'(a_item.row_number);
    prod   = (2*REG_W)'(y_row) * (2*REG_W)'(frame_width);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_take) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_take) begin
      b_mask   <= draw ? (a_item.row_bits & w_ones[ROW_W-1:0]) : '0;
      b_prod   <= prod[ADDR_W-1:0];
      b_px     <= a_item.pen_x;
      b_colour <= a_item.colour;
      b_bold   <= a_item.bold;
    end
  end

  // Emit stage: load a new row once the current one is drained, else clear the sent bit
  always_ff @(posedge clk) begin
    if (rst) begin
      c_mask <= '0;
    end else if (c_take) begin
      c_mask <= b_valid ? b_mask : '0;
    end else begin
      c_mask <= c_mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (c_take) begin
      c_base   <= b_prod + ADDR_W'(b_px);
      c_colour <= b_colour;
      c_bold   <= b_bold;
    end
  end

  // Encode the lowest pending column
  always_comb begin
    c_col = '0;
    for (int i = 0; i < ROW_W; i++) begin
      if (c_low[i]) c_col = c_col | COL_W'(i);
    end
  end

  // Pixel output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {c_colour, c_base + ADDR_W'(c_col)};
      m_tuser <= c_bold;
      m_tlast <= c_take;
    end
  end

`ifndef ASSERT_OFF
  // Input side stalls only while a row sits in the input register
  assert property (@(posedge clk) disable iff (rst) !s_tready |-> a_valid)
    else $error("input stalled with empty input register");

  // A non-final write must be followed by more of the same row
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid || (c_mask != '0))
    else $error("row ended without a final write");

  // Pending pixels move to a free output register
  assert property (@(posedge clk) disable iff (rst)
    (c_mask != '0) && (!m_tvalid || m_tready) |=> m_tvalid)
    else $error("pending pixel not emitted");
`endif

endmodule
